FILE: sv/reed_solomon_systematic_encoder_assert.svh
// assertion macros shared by the encoder rtl
`ifndef REED_SOLOMON_SYSTEMATIC_ENCODER_ASSERT_SVH
`define REED_SOLOMON_SYSTEMATIC_ENCODER_ASSERT_SVH

// same-cycle implication
`define RSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rse assertion failed in %m");

// next-cycle implication
`define RSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rse assertion failed in %m");

`endif

FILE: sv/rse_pkg.sv
package rse_pkg;

    // widest field the gf helpers handle
    localparam int MaxSymBits = 16;

    typedef logic [MaxSymBits-1:0] t_gf_word;
    typedef logic [7:0]            t_port_sym;

    // active field description: m ones, bit m-1, reduction taps below x^m
    typedef struct packed {
        t_gf_word mask;
        t_gf_word top;
        t_gf_word poly;
    } t_gf_field;

    typedef enum logic [1:0] {
        REG_FIELD_DEGREE   = 2'd0,
        REG_MESSAGE_LENGTH = 2'd1,
        REG_PARITY_COUNT   = 2'd2,
        REG_FIRST_ROOT     = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_GEN   = 2'd2,
        OP_SHIFT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

    function automatic logic [16:0] prim_poly(input logic [4:0] m);
        logic [16:0] p;
        unique case (m)
            5'd2:    p = 17'h00007;
            5'd3:    p = 17'h0000B;
            5'd4:    p = 17'h00019;
            5'd5:    p = 17'h00025;
            5'd6:    p = 17'h00043;
            5'd7:    p = 17'h00083;
            5'd8:    p = 17'h0011D;
            5'd9:    p = 17'h00211;
            5'd10:   p = 17'h00409;
            5'd11:   p = 17'h00805;
            5'd12:   p = 17'h01099;
            5'd13:   p = 17'h0201B;
            5'd14:   p = 17'h05803;
            5'd15:   p = 17'h08003;
            5'd16:   p = 17'h1002D;
            default: p = 17'h00007;
        endcase
        return p;
    endfunction

    // multiply by alpha in the active field
    function automatic t_gf_word gf_xtime(input t_gf_word v, input t_gf_field f);
        return ((v << 1) & f.mask) ^ (((v & f.top) != '0) ? f.poly : '0);
    endfunction

endpackage

FILE: sv/rse_if.sv
interface rse_data_if;
    logic                 valid;
    logic                 ready;
    rse_pkg::t_port_sym   data_symbol;

    modport source (output valid, output data_symbol, input ready);
    modport sink   (input valid, input data_symbol, output ready);
endinterface

interface rse_code_if;
    logic                 valid;
    logic                 ready;
    rse_pkg::t_port_sym   code_symbol;
    logic                 is_parity;
    logic                 last;
    logic                 config_error;

    modport source (output valid, output code_symbol, output is_parity, output last,
                    output config_error, input ready);
    modport sink   (input valid, input code_symbol, input is_parity, input last,
                    input config_error, output ready);
endinterface

interface rse_cfg_if;
    logic                 valid;
    logic                 ready;
    rse_pkg::t_cfg_reg    index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/rse_cell.sv
module rse_cell #(
    parameter int SYM_BITS = 8
) (
    input  logic                  i_clk,
    input  rse_pkg::t_cell_ctl    i_ctl,
    input  rse_pkg::t_gf_field    i_field,
    input  logic                  i_gen_seed,
    input  logic [SYM_BITS-1:0]   i_gen_prev,
    input  logic [SYM_BITS-1:0]   i_par_prev,
    input  logic [SYM_BITS-1:0]   i_operand,
    output logic [SYM_BITS-1:0]   o_gen,
    output logic [SYM_BITS-1:0]   o_par
);

    logic [SYM_BITS-1:0] r_gen;
    logic [SYM_BITS-1:0] r_par;
    logic [SYM_BITS-1:0] n_gen;
    logic [SYM_BITS-1:0] n_par;
    logic [SYM_BITS-1:0] w_prod;

    // horner shift-and-add, one step per operand bit
    function automatic logic [SYM_BITS-1:0] gf_mul(input logic [SYM_BITS-1:0] a,
                                                   input logic [SYM_BITS-1:0] b,
                                                   input rse_pkg::t_gf_field f);
        rse_pkg::t_gf_word acc;
        acc = '0;
        for (int i = SYM_BITS - 1; i >= 0; i--) begin
            acc = rse_pkg::gf_xtime(acc, f) ^ (b[i] ? rse_pkg::t_gf_word'(a) : '0);
        end
        return SYM_BITS'(acc);
    endfunction

    // one multiplier serves both generator build (by root) and encoding (by feedback)
    assign w_prod = gf_mul(r_gen, i_operand, i_field);

    always_comb begin
        n_gen = r_gen;
        n_par = r_par;
        unique case (i_ctl.op)
            rse_pkg::OP_HOLD: begin
            end
            rse_pkg::OP_CLEAR: begin
                n_gen = SYM_BITS'(i_gen_seed);
                n_par = '0;
            end
            rse_pkg::OP_GEN: begin
                n_gen = i_gen_prev ^ w_prod;
            end
            rse_pkg::OP_SHIFT: begin
                n_par = i_par_prev ^ w_prod;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_gen <= n_gen;
        r_par <= n_par;
    end

    assign o_gen = r_gen;
    assign o_par = r_par;

endmodule

FILE: sv/reed_solomon_systematic_encoder.sv
// channel   dir  modport  payload
// i_cfg     in   sink     index, data
// i_data    in   sink     data_symbol
// o_code    out  source   code_symbol, is_parity, last, config_error
//
// message symbols: one per cycle while o_code is free, via one output register
// parity: r symbols follow the k-th symbol, shifted out of the cell row; input waits
// after reset or a register write the next codeword start rebuilds the generator
// by an alpha power walk, then one root a cycle
// i_rst_n is synchronous; a stalled o_code holds its item and blocks new input
// config writes are always taken and apply at the next codeword start
`include "reed_solomon_systematic_encoder_assert.svh"

module reed_solomon_systematic_encoder #(
    parameter int SYM_BITS   = 8,
    parameter int MAX_PARITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rse_cfg_if.sink     i_cfg,
    rse_data_if.sink    i_data,
    rse_code_if.source  o_code
);

    localparam int RW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_ROOT = 4'b0010,
        ST_GEN  = 4'b0100,
        ST_PAR  = 4'b1000
    } t_state;

    // register shadows
    logic [3:0]          r_cfg_m,  n_cfg_m;
    logic [7:0]          r_cfg_k,  n_cfg_k;
    logic [5:0]          r_cfg_r,  n_cfg_r;
    logic [7:0]          r_cfg_fr, n_cfg_fr;
    logic                r_dirty,  n_dirty;

    // settings of the codeword in flight
    rse_pkg::t_gf_field  r_act_field, n_act_field;
    logic [7:0]          r_act_k,     n_act_k;
    logic [RW-1:0]       r_act_r,     n_act_r;
    logic [IW-1:0]       r_top_idx,   n_top_idx;
    logic                r_act_err,   n_act_err;

    t_state              r_state,    n_state;
    logic [7:0]          r_step_cnt, n_step_cnt;
    logic [SYM_BITS-1:0] r_root,     n_root;
    logic [7:0]          r_sym_cnt,  n_sym_cnt;
    logic [RW-1:0]       r_par_left, n_par_left;

    logic                r_out_valid, n_out_valid;
    rse_pkg::t_port_sym  r_out_sym,   n_out_sym;
    logic                r_out_par,   n_out_par;
    logic                r_out_last,  n_out_last;
    logic                r_out_err,   n_out_err;

    // latch values derived from the shadows
    logic [4:0]          w_m_sat;
    logic [16:0]         w_mask17;
    rse_pkg::t_gf_field  w_lat_field;
    logic [7:0]          w_k_sat;
    logic [RW-1:0]       w_r_sat;
    logic                w_lat_err;

    logic                w_cfg_acc;
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_need_build;
    logic [SYM_BITS-1:0] w_data_sym;
    logic [SYM_BITS-1:0] w_par_top;
    logic [7:0]          w_sym_inc;

    rse_pkg::t_cell_ctl  w_ctl;
    logic [SYM_BITS-1:0] w_operand;
    logic [SYM_BITS-1:0] w_gen      [MAX_PARITY];
    logic [SYM_BITS-1:0] w_par      [MAX_PARITY];
    logic [SYM_BITS-1:0] w_gen_prev [MAX_PARITY];
    logic [SYM_BITS-1:0] w_par_prev [MAX_PARITY];

    always_comb begin
        priority if (r_cfg_m < 4'd2) begin
            w_m_sat = 5'd2;
        end else if ({1'b0, r_cfg_m} > 5'(SYM_BITS)) begin
            w_m_sat = 5'(SYM_BITS);
        end else begin
            w_m_sat = {1'b0, r_cfg_m};
        end
        w_mask17         = (17'd1 << w_m_sat) - 17'd1;
        w_lat_field.mask = rse_pkg::t_gf_word'(w_mask17);
        w_lat_field.top  = rse_pkg::t_gf_word'(17'd1 << (w_m_sat - 5'd1));
        w_lat_field.poly = rse_pkg::t_gf_word'(rse_pkg::prim_poly(w_m_sat))
                           & rse_pkg::t_gf_word'(w_mask17);
        w_k_sat = (r_cfg_k == '0) ? 8'd1 : r_cfg_k;
        priority if (r_cfg_r == '0) begin
            w_r_sat = RW'(1);
        end else if (7'(r_cfg_r) > 7'(MAX_PARITY)) begin
            w_r_sat = RW'(MAX_PARITY);
        end else begin
            w_r_sat = RW'(r_cfg_r);
        end
        w_lat_err = (17'(w_k_sat) + 17'(w_r_sat)) > w_mask17;
    end

    assign w_cfg_acc    = i_cfg.valid && i_cfg.ready;
    assign w_out_free   = !r_out_valid || o_code.ready;
    assign w_need_build = r_dirty && (r_sym_cnt == '0);
    assign i_cfg.ready  = 1'b1;
    assign i_data.ready = (r_state == ST_RUN) && !w_need_build && w_out_free;
    assign w_in_acc     = i_data.valid && i_data.ready;

    assign w_data_sym = SYM_BITS'(rse_pkg::t_gf_word'(i_data.data_symbol))
                        & SYM_BITS'(r_act_field.mask);
    assign w_par_top  = w_par[r_top_idx];
    assign w_sym_inc  = r_sym_cnt + 8'd1;

    always_comb begin
        n_cfg_m     = r_cfg_m;
        n_cfg_k     = r_cfg_k;
        n_cfg_r     = r_cfg_r;
        n_cfg_fr    = r_cfg_fr;
        n_dirty     = r_dirty;
        n_act_field = r_act_field;
        n_act_k     = r_act_k;
        n_act_r     = r_act_r;
        n_top_idx   = r_top_idx;
        n_act_err   = r_act_err;
        n_state     = r_state;
        n_step_cnt  = r_step_cnt;
        n_root      = r_root;
        n_sym_cnt   = r_sym_cnt;
        n_par_left  = r_par_left;
        n_out_valid = r_out_valid && !o_code.ready;
        n_out_sym   = r_out_sym;
        n_out_par   = r_out_par;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        w_ctl.op    = rse_pkg::OP_HOLD;
        w_operand   = '0;

        if (w_cfg_acc) begin
            n_dirty = 1'b1;
            unique case (i_cfg.index)
                rse_pkg::REG_FIELD_DEGREE:   n_cfg_m  = i_cfg.data[3:0];
                rse_pkg::REG_MESSAGE_LENGTH: n_cfg_k  = i_cfg.data;
                rse_pkg::REG_PARITY_COUNT:   n_cfg_r  = i_cfg.data[5:0];
                rse_pkg::REG_FIRST_ROOT:     n_cfg_fr = i_cfg.data;
                default: begin
                end
            endcase
        end

        unique case (r_state)
            ST_RUN: begin
                if (w_need_build) begin
                    n_act_field = w_lat_field;
                    n_act_k     = w_k_sat;
                    n_act_r     = w_r_sat;
                    n_top_idx   = IW'(w_r_sat - RW'(1));
                    n_act_err   = w_lat_err;
                    n_root      = SYM_BITS'(1'b1);
                    n_step_cnt  = r_cfg_fr;
                    n_state     = ST_ROOT;
                    w_ctl.op    = rse_pkg::OP_CLEAR;
                    if (!w_cfg_acc) begin
                        n_dirty = 1'b0;
                    end
                end else if (w_in_acc) begin
                    w_ctl.op    = rse_pkg::OP_SHIFT;
                    w_operand   = w_data_sym ^ w_par_top;
                    n_out_valid = 1'b1;
                    n_out_sym   = rse_pkg::t_port_sym'(rse_pkg::t_gf_word'(w_data_sym));
                    n_out_par   = 1'b0;
                    n_out_last  = 1'b0;
                    n_out_err   = r_act_err;
                    if (w_sym_inc >= r_act_k) begin
                        n_sym_cnt  = '0;
                        n_par_left = r_act_r;
                        n_state    = ST_PAR;
                    end else begin
                        n_sym_cnt  = w_sym_inc;
                    end
                end
            end
            ST_ROOT: begin
                // walk alpha up to alpha^first_root
                if (r_step_cnt == '0) begin
                    n_step_cnt = 8'(r_act_r);
                    n_state    = ST_GEN;
                end else begin
                    n_root     = SYM_BITS'(rse_pkg::gf_xtime(
                                     rse_pkg::t_gf_word'(r_root), r_act_field));
                    n_step_cnt = r_step_cnt - 8'd1;
                end
            end
            ST_GEN: begin
                // fold one root (x + root) into the generator per cycle
                if (r_step_cnt == '0) begin
                    n_state = ST_RUN;
                end else begin
                    w_ctl.op   = rse_pkg::OP_GEN;
                    w_operand  = r_root;
                    n_root     = SYM_BITS'(rse_pkg::gf_xtime(
                                     rse_pkg::t_gf_word'(r_root), r_act_field));
                    n_step_cnt = r_step_cnt - 8'd1;
                end
            end
            ST_PAR: begin
                // zero feedback turns the row into a plain shift line, clearing it
                if (w_out_free) begin
                    w_ctl.op    = rse_pkg::OP_SHIFT;
                    w_operand   = '0;
                    n_out_valid = 1'b1;
                    n_out_sym   = rse_pkg::t_port_sym'(rse_pkg::t_gf_word'(w_par_top));
                    n_out_par   = 1'b1;
                    n_out_last  = (r_par_left == RW'(1));
                    n_out_err   = r_act_err;
                    n_par_left  = r_par_left - RW'(1);
                    if (r_par_left == RW'(1)) begin
                        n_state = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_m     <= 4'd8;
            r_cfg_k     <= 8'd223;
            r_cfg_r     <= 6'd32;
            r_cfg_fr    <= 8'd1;
            r_dirty     <= 1'b1;
            r_state     <= ST_RUN;
            r_step_cnt  <= '0;
            r_sym_cnt   <= '0;
            r_par_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg_m     <= n_cfg_m;
            r_cfg_k     <= n_cfg_k;
            r_cfg_r     <= n_cfg_r;
            r_cfg_fr    <= n_cfg_fr;
            r_dirty     <= n_dirty;
            r_state     <= n_state;
            r_step_cnt  <= n_step_cnt;
            r_sym_cnt   <= n_sym_cnt;
            r_par_left  <= n_par_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act_field <= n_act_field;
        r_act_k     <= n_act_k;
        r_act_r     <= n_act_r;
        r_top_idx   <= n_top_idx;
        r_act_err   <= n_act_err;
        r_root      <= n_root;
        r_out_sym   <= n_out_sym;
        r_out_par   <= n_out_par;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
    end

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign w_gen_prev[j] = '0;
            assign w_par_prev[j] = '0;
        end else begin : g_link
            assign w_gen_prev[j] = w_gen[j-1];
            assign w_par_prev[j] = w_par[j-1];
        end

        rse_cell #(
            .SYM_BITS (SYM_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_field    (r_act_field),
            .i_gen_seed (j == 0),
            .i_gen_prev (w_gen_prev[j]),
            .i_par_prev (w_par_prev[j]),
            .i_operand  (w_operand),
            .o_gen      (w_gen[j]),
            .o_par      (w_par[j])
        );
    end

    assign o_code.valid        = r_out_valid;
    assign o_code.code_symbol  = r_out_sym;
    assign o_code.is_parity    = r_out_par;
    assign o_code.last         = r_out_last;
    assign o_code.config_error = r_out_err;

    `RSE_ASSERT_IMP(a_last_is_parity, i_clk, i_rst_n, r_out_valid && r_out_last, r_out_par)
    `RSE_ASSERT_IMP(a_par_left_live, i_clk, i_rst_n, r_state == ST_PAR, r_par_left != '0)
    `RSE_ASSERT_NXT(a_gen_done, i_clk, i_rst_n, (r_state == ST_GEN) && (r_step_cnt == '0), r_state == ST_RUN)
    `RSE_ASSERT_IMP(a_count_idle, i_clk, i_rst_n, r_state != ST_RUN, r_sym_cnt == '0)

endmodule
